@@ src/wams_pkg.sv @@
// ----------------------------------------------------------------------------
// wams_pkg
// Request codes and the command/status bundles shared by the controller and
// the datapath of the weighted adjacency matrix store.
// ----------------------------------------------------------------------------
package wams_pkg;

  // Request kinds carried on the kind port.
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_LIST   = 2'd3
  } kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;  // write zero at the clear pointer and advance it
    logic load;      // capture a new item
    logic decide;    // point request: read data is back, form the result
    logic mirror;    // write the mirror entry
    logic scan;      // read the next row of the listed column
    logic flush;     // emit the final result of a listing
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;    // clear pointer is on the last entry
    logic is_list;     // captured item is a neighbor listing
    logic a_ok;        // captured first vertex is in range
    logic need_write;  // point request changes the matrix
    logic scan_last;   // scan is on the last active row
  } ctrl_status_t;

endpackage

@@ src/wams_ram.sv @@
// ----------------------------------------------------------------------------
// wams_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module wams_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ src/wams_ctrl.sv @@
// ----------------------------------------------------------------------------
// wams_ctrl
// Sequencer for the adjacency matrix store: runs the clearing pass after
// reset, then steps each item through read, decide and write, or through a
// column scan for neighbor listings.
// ----------------------------------------------------------------------------
module wams_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  output wams_pkg::ctrl_cmd_t      cmd,
  input  wams_pkg::ctrl_status_t   status
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_DECIDE,
    S_MIRROR,
    S_SCAN,
    S_DRAIN,
    S_FLUSH
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands, decoded from the current state, start and status.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        if (status.is_list) begin
          state_next = status.a_ok ? S_SCAN : S_FLUSH;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = status.need_write ? S_MIRROR : S_IDLE;
      end
      S_MIRROR: begin
        cmd.mirror = 1'b1;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FLUSH;
      end
      S_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register and the registered busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy  <= 1'b1;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

`ifndef ASSERT_OFF
  // Busy is low exactly while the sequencer waits for an item.
  a_busy_idle: assert property (@(posedge clk) disable iff (rst)
    busy == (state != S_IDLE))
    else $error("busy does not match the idle state");

  // A decided point request either writes its mirror entry or finishes.
  a_decide_next: assert property (@(posedge clk) disable iff (rst)
    state == S_DECIDE |=> (state == S_MIRROR || state == S_IDLE))
    else $error("point request left the decide step wrongly");
`endif

endmodule

@@ src/wams_datapath.sv @@
// ----------------------------------------------------------------------------
// wams_datapath
// Holds the vertex count register, the captured item, the weight matrix
// memory, the scan and clear pointers and the registered result ports.
// ----------------------------------------------------------------------------
module wams_datapath #(
  parameter int MAX_VERTICES = 64,
  parameter int WEIGHT_BITS  = 16,
  parameter int VERTEX_BITS  = $clog2(MAX_VERTICES),
  parameter int COUNT_BITS   = $clog2(MAX_VERTICES + 1),
  parameter int VALUE_BITS   = (WEIGHT_BITS > VERTEX_BITS) ? WEIGHT_BITS : VERTEX_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  wams_pkg::ctrl_cmd_t      cmd,
  output wams_pkg::ctrl_status_t   status,
  input  logic                     cfg_write,
  input  logic [COUNT_BITS-1:0]    cfg_data,
  input  logic [1:0]               kind,
  input  logic [VERTEX_BITS-1:0]   vertex_a,
  input  logic [VERTEX_BITS-1:0]   vertex_b,
  input  logic [WEIGHT_BITS-1:0]   weight,
  output logic                     done,
  output logic                     status_bit,
  output logic                     found,
  output logic [VALUE_BITS-1:0]    value,
  output logic                     last
);

  localparam int ADDR_BITS = 2 * VERTEX_BITS;
  localparam int DEPTH     = 1 << ADDR_BITS;

  logic [COUNT_BITS-1:0]  vertices_in_use;
  logic [COUNT_BITS-1:0]  active_n;
  wams_pkg::kind_t        kind_q;
  logic [VERTEX_BITS-1:0] a_q;
  logic [VERTEX_BITS-1:0] b_q;
  logic [WEIGHT_BITS-1:0] w_q;
  logic                   a_ok_q;
  logic                   pair_ok_q;
  logic [ADDR_BITS-1:0]   clr_cnt;
  logic [VERTEX_BITS-1:0] row;
  logic                   rd_valid;
  logic [VERTEX_BITS-1:0] rd_row;
  logic                   pend_valid;
  logic [VERTEX_BITS-1:0] pend_row;
  logic                   in_a_ok;
  logic                   in_b_ok;
  logic                   rd_nonzero;
  logic                   point_ok;
  logic                   scan_cmd;

  logic                   mem_wr_en;
  logic [ADDR_BITS-1:0]   mem_wr_addr;
  logic [WEIGHT_BITS-1:0] mem_wr_data;
  logic [ADDR_BITS-1:0]   mem_rd_addr;
  logic [WEIGHT_BITS-1:0] mem_rd_data;

  logic                   done_next;
  logic                   status_next;
  logic                   found_next;
  logic [VALUE_BITS-1:0]  value_next;
  logic                   last_next;

  // Vertex count register; larger values act as the full matrix.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertices_in_use <= COUNT_BITS'(MAX_VERTICES);
    end else if (cfg_write) begin
      vertices_in_use <= cfg_data;
    end
  end

  assign active_n = (vertices_in_use > COUNT_BITS'(MAX_VERTICES)) ?
                    COUNT_BITS'(MAX_VERTICES) : vertices_in_use;
  assign in_a_ok  = COUNT_BITS'(vertex_a) < active_n;
  assign in_b_ok  = COUNT_BITS'(vertex_b) < active_n;

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q    <= wams_pkg::kind_t'(kind);
      a_q       <= vertex_a;
      b_q       <= vertex_b;
      w_q       <= weight;
      a_ok_q    <= in_a_ok;
      pair_ok_q <= in_a_ok && in_b_ok;
    end
  end

  // Clear pointer, scan pointer and the pending neighbor of a listing.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      row        <= '0;
      rd_valid   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + ADDR_BITS'(1);
      end
      if (cmd.load) begin
        row        <= '0;
        pend_valid <= 1'b0;
      end else if (cmd.scan) begin
        row <= row + VERTEX_BITS'(1);
      end
      rd_valid <= cmd.scan;
      if (rd_valid && rd_nonzero) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_row <= row;
    if (rd_valid && rd_nonzero) begin
      pend_row <= rd_row;
    end
  end

  // Memory ports: row-major addressing, entry (r, c) at {r, c}.
  assign rd_nonzero  = (mem_rd_data != '0);
  assign mem_wr_en   = cmd.clr_step || (cmd.decide && status.need_write) || cmd.mirror;
  assign mem_rd_addr = cmd.scan ? {row, a_q} : {a_q, b_q};

  always_comb begin
    if (cmd.clr_step) begin
      mem_wr_addr = clr_cnt;
      mem_wr_data = '0;
    end else begin
      mem_wr_addr = cmd.mirror ? {b_q, a_q} : {a_q, b_q};
      mem_wr_data = (kind_q == wams_pkg::KIND_INSERT) ? w_q : '0;
    end
  end

  wams_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (DEPTH)
  ) u_matrix (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Point requests succeed on an empty slot for insert, a full one for remove.
  always_comb begin
    case (kind_q)
      wams_pkg::KIND_INSERT: point_ok = pair_ok_q && !rd_nonzero;
      wams_pkg::KIND_REMOVE: point_ok = pair_ok_q && rd_nonzero;
      default:               point_ok = pair_ok_q;
    endcase
  end

  assign status.clr_last   = &clr_cnt;
  assign status.is_list    = (kind_q == wams_pkg::KIND_LIST);
  assign status.a_ok       = a_ok_q;
  assign status.need_write = point_ok && ((kind_q == wams_pkg::KIND_INSERT) ||
                                          (kind_q == wams_pkg::KIND_REMOVE));
  assign status.scan_last  = (COUNT_BITS'(row) == active_n - COUNT_BITS'(1));

  // Result forming.
  always_comb begin
    done_next   = 1'b0;
    status_next = 1'b0;
    found_next  = 1'b0;
    value_next  = '0;
    last_next   = 1'b0;
    if (cmd.decide) begin
      done_next   = 1'b1;
      last_next   = 1'b1;
      status_next = !point_ok;
      if (kind_q == wams_pkg::KIND_QUERY) begin
        found_next = point_ok && rd_nonzero;
      end
      if (kind_q == wams_pkg::KIND_REMOVE && point_ok) begin
        value_next = VALUE_BITS'(mem_rd_data);
      end
    end else if (cmd.flush) begin
      done_next   = 1'b1;
      last_next   = 1'b1;
      status_next = !a_ok_q;
      if (pend_valid) begin
        found_next = 1'b1;
        value_next = VALUE_BITS'(pend_row);
      end
    end else if (rd_valid && rd_nonzero && pend_valid) begin
      // A newer neighbor shows the held one is not the final item.
      done_next  = 1'b1;
      found_next = 1'b1;
      value_next = VALUE_BITS'(pend_row);
    end
  end

  // Registered result ports.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= done_next;
    end
    status_bit <= status_next;
    found      <= found_next;
    value      <= value_next;
    last       <= last_next;
  end

  assign scan_cmd = cmd.scan;

`ifndef ASSERT_OFF
  // Read data is only taken as a scan row in the cycle after a scan read.
  a_rd_valid_scan: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> $past(scan_cmd))
    else $error("scan read data without a scan read");

  // Every item of a listing but the final one names a neighbor.
  a_mid_item: assert property (@(posedge clk) disable iff (rst)
    done && !last |-> found && !status_bit)
    else $error("intermediate item does not name a neighbor");

  // A rejected item carries nothing but its status.
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    done && status_bit |-> !found && value == '0 && last)
    else $error("rejected item carries data");
`endif

endmodule

@@ src/weighted_adjacency_matrix_store.sv @@
// ----------------------------------------------------------------------------
// weighted_adjacency_matrix_store
// Symmetric weight matrix of an undirected graph with insert, remove, query
// and neighbor listing requests.
// ----------------------------------------------------------------------------
// Usage:
//   Drive kind, vertex_a, vertex_b and weight with start high; the item is
//   taken at a clock edge where start is high and busy is low. Results come
//   on status, found, value and last, each valid for the single cycle in
//   which done is high; the receiver cannot stall them. last marks the
//   final result of an item.
//   Insert, remove and query give one result each. The entry is read in
//   the setup state and the result is formed in the decide state, which
//   also writes the entry on a change; the mirror state then writes the
//   mirror entry, since the memory has a single write port. A listing
//   reads one matrix row per cycle from the single memory read port, for
//   each of the n active vertices; neighbor results come one per nonzero
//   entry in ascending order, and the final result follows the scan. An
//   out-of-range listing skips the scan and gives only its final result.
//   After reset the matrix memory is cleared one entry a cycle, all
//   2^(2*clog2(MAX_VERTICES)) entries (4096 by default); busy is high then.
//   The vertex count is written by cfg_write/cfg_data, reset to MAX_VERTICES,
//   and should change only while the block is idle.
// ----------------------------------------------------------------------------
module weighted_adjacency_matrix_store #(
  parameter int MAX_VERTICES = 64,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [$clog2(MAX_VERTICES + 1)-1:0]    cfg_data,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             kind,
  input  logic [$clog2(MAX_VERTICES)-1:0]        vertex_a,
  input  logic [$clog2(MAX_VERTICES)-1:0]        vertex_b,
  input  logic [WEIGHT_BITS-1:0]                 weight,
  output logic                                   done,
  output logic                                   status,
  output logic                                   found,
  output logic [((WEIGHT_BITS > $clog2(MAX_VERTICES)) ?
                 WEIGHT_BITS : $clog2(MAX_VERTICES))-1:0] value,
  output logic                                   last
);

  wams_pkg::ctrl_cmd_t    cmd;
  wams_pkg::ctrl_status_t ctl_status;

  // Sequencer.
  wams_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (ctl_status)
  );

  // Matrix memory, pointers and result registers.
  wams_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (ctl_status),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .kind       (kind),
    .vertex_a   (vertex_a),
    .vertex_b   (vertex_b),
    .weight     (weight),
    .done       (done),
    .status_bit (status),
    .found      (found),
    .value      (value),
    .last       (last)
  );

endmodule
